// ----- sv/pebb_pkg.sv -----
// Shared types, segment opcodes and the end-point decoder for the path bounding box.
// No dependencies; every other file uses this package by scoped names.

package pebb_pkg;

  // Fixed payload widths of the channels.
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned INT_W   = 16;   // integer coordinate mode width

  // Segment opcode: the command byte without its relative bit.
  typedef logic [CODE_W-2:0] seg_op_t;

  localparam seg_op_t OP_CLOSE   = 7'd0;
  localparam seg_op_t OP_MOVE    = 7'd1;
  localparam seg_op_t OP_LINE    = 7'd2;
  localparam seg_op_t OP_HLINE   = 7'd3;
  localparam seg_op_t OP_VLINE   = 7'd4;
  localparam seg_op_t OP_QUAD    = 7'd5;
  localparam seg_op_t OP_CUBIC   = 7'd6;
  localparam seg_op_t OP_SQUAD   = 7'd7;
  localparam seg_op_t OP_SCUBIC  = 7'd8;
  localparam seg_op_t OP_SCCWARC = 7'd9;
  localparam seg_op_t OP_SCWARC  = 7'd10;
  localparam seg_op_t OP_LCCWARC = 7'd11;
  localparam seg_op_t OP_LCWARC  = 7'd12;

  // Coordinate format register values.
  localparam logic FMT_INT   = 1'b0;
  localparam logic FMT_FIXED = 1'b1;

  // Coordinate slot of a segment.
  typedef logic [2:0] coord_idx_t;

  // One segment request.
  typedef struct packed {
    logic [CODE_W-1:0]         seg_code;
    logic signed [FIELD_W-1:0] coord_0;
    logic signed [FIELD_W-1:0] coord_1;
    logic signed [FIELD_W-1:0] coord_2;
    logic signed [FIELD_W-1:0] coord_3;
    logic signed [FIELD_W-1:0] coord_4;
    logic signed [FIELD_W-1:0] coord_5;
    logic                      last_segment;
  } seg_t;

  // One bounding box result.
  typedef struct packed {
    logic signed [FIELD_W-1:0] box_min_x;
    logic signed [FIELD_W-1:0] box_min_y;
    logic [FIELD_W-1:0]        box_width;
    logic [FIELD_W-1:0]        box_height;
  } box_t;

  // Which coordinates carry the end point, and how they apply.
  typedef struct packed {
    logic       upd_x;
    logic       upd_y;
    logic       rel;
    coord_idx_t x_idx;
    coord_idx_t y_idx;
  } ep_sel_t;

  function automatic ep_sel_t decode_endpoint(logic [CODE_W-1:0] code);
    ep_sel_t s;
    s.upd_x = 1'b0;
    s.upd_y = 1'b0;
    s.rel   = code[0];
    s.x_idx = 3'd0;
    s.y_idx = 3'd1;
    unique case (code[CODE_W-1:1])
      OP_MOVE, OP_LINE, OP_SQUAD: begin
        s.upd_x = 1'b1;
        s.upd_y = 1'b1;
      end
      OP_HLINE: begin
        s.upd_x = 1'b1;
      end
      OP_VLINE: begin
        s.upd_y = 1'b1;
        s.y_idx = 3'd0;
      end
      OP_QUAD, OP_SCUBIC: begin
        s.upd_x = 1'b1;
        s.upd_y = 1'b1;
        s.x_idx = 3'd2;
        s.y_idx = 3'd3;
      end
      OP_CUBIC: begin
        s.upd_x = 1'b1;
        s.upd_y = 1'b1;
        s.x_idx = 3'd4;
        s.y_idx = 3'd5;
      end
      OP_SCCWARC, OP_SCWARC, OP_LCCWARC, OP_LCWARC: begin
        s.upd_x = 1'b1;
        s.upd_y = 1'b1;
        s.x_idx = 3'd3;
        s.y_idx = 3'd4;
      end
      default: begin
        // close and unknown codes keep the pen
      end
    endcase
    return s;
  endfunction

endpackage

// ----- sv/pebb_seg_if.sv -----
// Valid/ready channel carrying segment requests into the block.
// Depends on pebb_pkg for the payload type.

interface pebb_seg_if;
  logic          valid;
  logic          ready;
  pebb_pkg::seg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pebb_box_if.sv -----
// Valid/ready channel carrying bounding box results out of the block.
// Depends on pebb_pkg for the payload type.

interface pebb_box_if;
  logic          valid;
  logic          ready;
  pebb_pkg::box_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pebb_step.sv -----
// Combinational pen update and box widening for one segment.
// Depends on pebb_pkg (segment type, end-point decoder).

module pebb_step #(
  parameter int unsigned CW = 32
) (
  input  logic                 fmt,
  input  pebb_pkg::seg_t       seg,
  input  logic signed [CW-1:0] pen_x,
  input  logic signed [CW-1:0] pen_y,
  input  logic signed [CW-1:0] low_x,
  input  logic signed [CW-1:0] low_y,
  input  logic signed [CW-1:0] high_x,
  input  logic signed [CW-1:0] high_y,
  output logic signed [CW-1:0] pen_x_next,
  output logic signed [CW-1:0] pen_y_next,
  output logic signed [CW-1:0] low_x_next,
  output logic signed [CW-1:0] low_y_next,
  output logic signed [CW-1:0] high_x_next,
  output logic signed [CW-1:0] high_y_next
);

  // Wrap to the active coordinate width, sign extended to CW.
  function automatic logic signed [CW-1:0] wrap(logic [CW-1:0] v, logic f);
    logic signed [pebb_pkg::INT_W-1:0] t;
    t = v[pebb_pkg::INT_W-1:0];
    return (f == pebb_pkg::FMT_FIXED) ? v : CW'(t);
  endfunction

  pebb_pkg::ep_sel_t    sel;
  logic signed [CW-1:0] c [6];
  logic signed [CW-1:0] cx, cy;
  logic [CW-1:0]        sum_x, sum_y;

  assign sel = pebb_pkg::decode_endpoint(seg.seg_code);

  assign c[0] = wrap(seg.coord_0[CW-1:0], fmt);
  assign c[1] = wrap(seg.coord_1[CW-1:0], fmt);
  assign c[2] = wrap(seg.coord_2[CW-1:0], fmt);
  assign c[3] = wrap(seg.coord_3[CW-1:0], fmt);
  assign c[4] = wrap(seg.coord_4[CW-1:0], fmt);
  assign c[5] = wrap(seg.coord_5[CW-1:0], fmt);

  always_comb begin
    cx = c[0];
    cy = c[0];
    for (int i = 0; i < 6; i++) begin
      if (sel.x_idx == 3'(i)) cx = c[i];
      if (sel.y_idx == 3'(i)) cy = c[i];
    end
  end

  assign sum_x = pen_x + cx;
  assign sum_y = pen_y + cy;

  always_comb begin
    pen_x_next = pen_x;
    pen_y_next = pen_y;
    if (sel.upd_x) pen_x_next = sel.rel ? wrap(sum_x, fmt) : cx;
    if (sel.upd_y) pen_y_next = sel.rel ? wrap(sum_y, fmt) : cy;
  end

  assign low_x_next  = (pen_x_next < low_x)  ? pen_x_next : low_x;
  assign low_y_next  = (pen_y_next < low_y)  ? pen_y_next : low_y;
  assign high_x_next = (pen_x_next > high_x) ? pen_x_next : high_x;
  assign high_y_next = (pen_y_next > high_y) ? pen_y_next : high_y;

endmodule

// ----- sv/path_endpoint_bounding_box_top.sv -----
// Path end-point bounding box: top level with segment register, state and result register.
// Depends on pebb_pkg, pebb_seg_if, pebb_box_if and pebb_step.

// Takes one path segment request per cycle, tracks the pen from each segment's
// end point (absolute codes load it, relative codes add to it) and widens a box
// that always includes the origin. On the request marked last_segment the block
// hands out the box's minimum corner, width and height and starts the next path
// from a cleared state. Throughput is one segment per clock. A result is offered
// from the result register once its last segment leaves the segment register.
// A last segment that meets a result still waiting for box.ready holds in the
// segment register and stalls the input until the result leaves. The rate is
// set by the pen loop: the end-point add and the four bound compares close
// combinationally on the state registers. coord_format selects 16-bit integer
// (0) or COORD_WIDTH-bit fixed-point (1) coordinates and must only be written
// while no path is in flight.

module path_endpoint_bounding_box_top #(
  parameter int unsigned COORD_WIDTH = 32   // 16..32
) (
  input  logic            clk,
  input  logic            rst,
  pebb_seg_if.sink        seg,
  pebb_box_if.source      box,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned FW = pebb_pkg::FIELD_W;

  // Config
  logic coord_format;

  // Segment register
  logic           s1_valid;
  pebb_pkg::seg_t s1_seg;
  logic           s1_go;

  // Path state
  logic signed [CW-1:0] pen_x, pen_y, low_x, low_y, high_x, high_y;
  logic signed [CW-1:0] pen_x_next, pen_y_next;
  logic signed [CW-1:0] low_x_next, low_y_next, high_x_next, high_y_next;

  // Result register: box corners
  logic                 out_valid;
  logic                 out_load;
  logic signed [CW-1:0] out_min_x, out_min_y, out_max_x, out_max_y;
  logic [CW:0]          span_x, span_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_format <= pebb_pkg::FMT_INT;
    end else if (cfg_we) begin
      coord_format <= cfg_wdata;
    end
  end

  // The segment register drains unless it holds a last segment facing a full,
  // stalled result register.
  assign s1_go     = s1_valid && (!s1_seg.last_segment || !out_valid || box.ready);
  assign seg.ready = !s1_valid || s1_go;
  assign out_load  = s1_go && s1_seg.last_segment;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seg.ready) begin
      s1_valid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      s1_seg <= seg.data;
    end
  end

  pebb_step #(.CW(CW)) u_step (
    .fmt         (coord_format),
    .seg         (s1_seg),
    .pen_x       (pen_x),
    .pen_y       (pen_y),
    .low_x       (low_x),
    .low_y       (low_y),
    .high_x      (high_x),
    .high_y      (high_y),
    .pen_x_next  (pen_x_next),
    .pen_y_next  (pen_y_next),
    .low_x_next  (low_x_next),
    .low_y_next  (low_y_next),
    .high_x_next (high_x_next),
    .high_y_next (high_y_next)
  );

  // Last segment clears the path state for the next path.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x  <= '0;
      pen_y  <= '0;
      low_x  <= '0;
      low_y  <= '0;
      high_x <= '0;
      high_y <= '0;
    end else if (s1_go) begin
      if (s1_seg.last_segment) begin
        pen_x  <= '0;
        pen_y  <= '0;
        low_x  <= '0;
        low_y  <= '0;
        high_x <= '0;
        high_y <= '0;
      end else begin
        pen_x  <= pen_x_next;
        pen_y  <= pen_y_next;
        low_x  <= low_x_next;
        low_y  <= low_y_next;
        high_x <= high_x_next;
        high_y <= high_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (box.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_x <= low_x_next;
      out_min_y <= low_y_next;
      out_max_x <= high_x_next;
      out_max_y <= high_y_next;
    end
  end

  // Exact spans; always non-negative and below 2^CW.
  assign span_x = {out_max_x[CW-1], out_max_x} - {out_min_x[CW-1], out_min_x};
  assign span_y = {out_max_y[CW-1], out_max_y} - {out_min_y[CW-1], out_min_y};

  assign box.valid          = out_valid;
  assign box.data.box_min_x = FW'(out_min_x);
  assign box.data.box_min_y = FW'(out_min_y);
  assign box.data.box_width  = FW'(span_x);
  assign box.data.box_height = FW'(span_y);

  // The box always contains the origin.
  a_origin_in_box: assert property (@(posedge clk) disable iff (rst)
    low_x <= 0 && high_x >= 0 && low_y <= 0 && high_y >= 0)
    else $error("box lost the origin");

  // The pen always lies inside the box.
  a_pen_in_box: assert property (@(posedge clk) disable iff (rst)
    low_x <= pen_x && pen_x <= high_x && low_y <= pen_y && pen_y <= high_y)
    else $error("pen outside box");

  // A finished path leaves cleared state behind.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_seg.last_segment |=>
      pen_x == 0 && pen_y == 0 && low_x == 0 && high_x == 0 && low_y == 0 && high_y == 0)
    else $error("state not cleared after last segment");

  // A result is only ever produced by a last segment.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_seg.last_segment))
    else $error("result without last segment");

endmodule
